// ----- hw/rtl/srgbmip_pkg.sv -----
// Package: shared types, defaults and sRGB table builders for the mip downsampler.
package srgbmip_pkg;

  localparam int unsigned TileMaxDefault    = 128;
  localparam int unsigned LinearBitsDefault = 16;

  typedef logic [31:0] tab_t [256];

  typedef enum logic [2:0] {
    K_DROP  = 3'd0,
    K_EVEN  = 3'd1,
    K_UPPER = 3'd2,
    K_LOWER = 3'd3,
    K_ONE   = 3'd4
  } kind_e;

  typedef struct packed {
    logic       load;
    logic       mul;
    logic       acc;
    kind_e      kind;
    logic       div_step;
    logic       enc_step;
    logic [2:0] enc_bit;
    logic       emit;
    logic       done;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] qmul(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * b;
    return p >> 30;
  endfunction

  function automatic logic [63:0] pow5(input logic [63:0] r);
    logic [63:0] r2;
    logic [63:0] r4;
    r2 = qmul(r, r);
    r4 = qmul(r2, r2);
    return qmul(r4, r);
  endfunction

  function automatic logic [31:0] linear_of(input logic [63:0] num, input logic [63:0] den,
                                            input int unsigned lb);
    logic [63:0] l;
    logic [63:0] q;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] t4;
    logic [63:0] t8;
    logic [63:0] t12;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] lim;
    lim = (64'd1 << lb) - 64'd1;
    if (num * 64'd100000 <= den * 64'd4045) begin
      l = udiv((num * 64'd100) << 30, den * 64'd1292);
    end else begin
      t   = udiv((num * 64'd1000 + den * 64'd55) << 30, den * 64'd1055);
      t2  = qmul(t, t);
      t4  = qmul(t2, t2);
      t8  = qmul(t4, t4);
      t12 = qmul(t8, t4);
      lo  = '0;
      hi  = 64'd1 << 30;
      while (lo < hi) begin
        mid = lo + ((hi - lo + 64'd1) >> 1);
        if (pow5(mid) <= t12) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
      l = lo;
    end
    q = ((l << lb) + (64'd1 << 29)) >> 30;
    if (q > lim) begin
      q = lim;
    end
    return q[31:0];
  endfunction

  function automatic tab_t build_decode(input int unsigned lb);
    tab_t tb;
    for (int i = 0; i < 256; i++) begin
      tb[i] = linear_of(64'(i), 64'd255, lb);
    end
    return tb;
  endfunction

  function automatic tab_t build_encode(input int unsigned lb);
    tab_t tb;
    tb[0] = '0;
    for (int i = 1; i < 256; i++) begin
      tb[i] = linear_of(64'(2 * i - 1), 64'd510, lb);
    end
    return tb;
  endfunction

endpackage

// ----- hw/rtl/srgbmip_if.sv -----
// Interfaces: source pixel request channel and downsampled pixel request channel.
interface srgbmip_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic [7:0] alpha_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output alpha_in, input ready);
  modport sink (input valid, input red_in, input green_in, input blue_in,
                input alpha_in, output ready);
endinterface

interface srgbmip_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic [7:0] alpha_out;
  logic       tile_done;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output alpha_out, output tile_done, input ready);
  modport sink (input valid, input red_out, input green_out, input blue_out,
                input alpha_out, input tile_done, output ready);
endinterface

// ----- hw/rtl/srgbmip_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module srgbmip_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hw/rtl/srgbmip_ctrl.sv -----
// Controller: tile counters, tile size register and sequencing state machine.
module srgbmip_ctrl #(
  parameter int unsigned TILE_MAX    = srgbmip_pkg::TileMaxDefault,
  parameter int unsigned LINEAR_BITS = srgbmip_pkg::LinearBitsDefault,
  localparam int unsigned HalfMax = TILE_MAX / 2,
  localparam int unsigned AddrW   = (HalfMax > 1) ? $clog2(HalfMax) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cfg_we_i,
  input  logic [7:0]          cfg_wdata_i,
  output srgbmip_pkg::cmd_t   cmd_o,
  output logic [AddrW-1:0]    rd_idx_o,
  input  srgbmip_pkg::sts_t   sts_i
);

  localparam int unsigned SW   = $clog2(TILE_MAX + 1);
  localparam int unsigned XW   = (SW > 8) ? SW : 8;
  localparam int unsigned DivN = LINEAR_BITS + 10;
  localparam int unsigned CntW = $clog2(DivN);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MUL  = 6'b000010,
    S_ACC  = 6'b000100,
    S_DIV  = 6'b001000,
    S_ENC  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  state_e             state_q, state_d;
  logic [7:0]         size_cfg_q;
  logic [SW-1:0]      col_q, col_d, row_q, row_d;
  srgbmip_pkg::kind_e kind_q, kind_d;
  logic               done_q, done_d;
  logic [AddrW-1:0]   idx_q, idx_d;
  logic [CntW-1:0]    cnt_q, cnt_d;

  logic [XW-1:0] cfg_x;
  logic [XW-1:0] size_x;
  logic [SW-1:0] size_s;
  logic [SW-1:0] full_s;
  logic [SW:0]   col_inc;
  logic [SW:0]   row_inc;
  logic          accept;

  assign cfg_x  = XW'(size_cfg_q);
  assign size_x = (cfg_x == '0) ? XW'(1) :
                  (cfg_x > XW'(TILE_MAX)) ? XW'(TILE_MAX) : cfg_x;
  assign size_s = SW'(size_x);
  assign full_s = {size_s[SW-1:1], 1'b0};
  assign col_inc = {1'b0, col_q} + (SW+1)'(1);
  assign row_inc = {1'b0, row_q} + (SW+1)'(1);

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_ready_o && in_valid_i;
  assign rd_idx_o   = idx_q;

  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    row_d   = row_q;
    kind_d  = kind_q;
    done_d  = done_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.kind    = kind_q;
    cmd_o.done    = done_q;
    cmd_o.enc_bit = 3'(3'd7 - 3'(cnt_q));
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.load = 1'b1;
          idx_d  = col_q[AddrW:1];
          done_d = 1'b0;
          if (size_s == SW'(1)) begin
            kind_d = srgbmip_pkg::K_ONE;
            done_d = 1'b1;
          end else if (col_q < full_s && row_q < full_s) begin
            if (!col_q[0]) begin
              kind_d = srgbmip_pkg::K_EVEN;
            end else if (!row_q[0]) begin
              kind_d = srgbmip_pkg::K_UPPER;
            end else begin
              kind_d = srgbmip_pkg::K_LOWER;
              done_d = (row_q == full_s - SW'(1)) && (col_q == full_s - SW'(1));
            end
          end else begin
            kind_d = srgbmip_pkg::K_DROP;
          end
          if (size_s == SW'(1)) begin
            col_d = '0;
            row_d = '0;
          end else if (col_inc >= {1'b0, size_s}) begin
            col_d = '0;
            row_d = (row_inc >= {1'b0, size_s}) ? '0 : row_inc[SW-1:0];
          end else begin
            col_d = col_inc[SW-1:0];
          end
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        cnt_d     = '0;
        if (kind_q == srgbmip_pkg::K_LOWER || kind_q == srgbmip_pkg::K_ONE) begin
          state_d = S_DIV;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CntW'(DivN - 1)) begin
          cnt_d   = '0;
          state_d = S_ENC;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      S_ENC: begin
        cmd_o.enc_step = 1'b1;
        if (cnt_q == CntW'(7)) begin
          cnt_d   = '0;
          state_d = S_OUT;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end
      S_OUT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (cfg_we_i) begin
      col_d = '0;
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      size_cfg_q <= 8'd128;
      col_q      <= '0;
      row_q      <= '0;
      kind_q     <= srgbmip_pkg::K_DROP;
      done_q     <= 1'b0;
      idx_q      <= '0;
      cnt_q      <= '0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      row_q   <= row_d;
      kind_q  <= kind_d;
      done_q  <= done_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        size_cfg_q <= cfg_wdata_i;
      end
    end
  end

endmodule

// ----- hw/rtl/srgbmip_dp.sv -----
// Datapath: sRGB decode, alpha weighting, row accumulation, dividers and encoders.
module srgbmip_dp #(
  parameter int unsigned TILE_MAX    = srgbmip_pkg::TileMaxDefault,
  parameter int unsigned LINEAR_BITS = srgbmip_pkg::LinearBitsDefault,
  localparam int unsigned HalfMax = TILE_MAX / 2,
  localparam int unsigned AddrW   = (HalfMax > 1) ? $clog2(HalfMax) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [7:0]        red_i,
  input  logic [7:0]        green_i,
  input  logic [7:0]        blue_i,
  input  logic [7:0]        alpha_i,
  input  srgbmip_pkg::cmd_t cmd_i,
  input  logic [AddrW-1:0]  rd_idx_i,
  output srgbmip_pkg::sts_t sts_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o,
  output logic [7:0]        alpha_o,
  output logic              tile_done_o
);

  localparam int unsigned LB   = LINEAR_BITS;
  localparam int unsigned WW   = LB + 8;
  localparam int unsigned PW   = LB + 9;
  localparam int unsigned TW   = LB + 10;
  localparam int unsigned RamW = 3 * PW + 9;
  localparam int unsigned RamD = (HalfMax > 1) ? HalfMax : 1;

  localparam srgbmip_pkg::tab_t DecRom = srgbmip_pkg::build_decode(LB);
  localparam srgbmip_pkg::tab_t EncThr = srgbmip_pkg::build_encode(LB);

  logic [7:0]      pin [3];
  logic [LB-1:0]   lin_q [3];
  logic [7:0]      a_q;
  logic [WW-1:0]   w_q [3];
  logic [WW-1:0]   p_q [3];
  logic [7:0]      pa_q;
  logic [PW-1:0]   s [3];
  logic [8:0]      sa;
  logic [PW-1:0]   rs [3];
  logic [8:0]      ra;
  logic [TW-1:0]   t [3];
  logic [9:0]      ta;
  logic [RamW-1:0] ram_wdata;
  logic [RamW-1:0] ram_rdata;
  logic            ram_we;
  logic            div_load;

  logic [TW-1:0]   n_q [3];
  logic [9:0]      rem_q [3];
  logic [9:0]      den_q;
  logic            zero_q;
  logic [9:0]      asum_q;
  logic            done_q;
  logic [7:0]      code_q [3];
  logic [10:0]     r_ext [3];
  logic            ge [3];
  logic [7:0]      cand [3];
  logic            out_valid_q;

  assign pin[0] = red_i;
  assign pin[1] = green_i;
  assign pin[2] = blue_i;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      s[ch] = PW'(p_q[ch]) + PW'(w_q[ch]);
    end
    sa = 9'(pa_q) + 9'(a_q);
    rs[0] = ram_rdata[3*PW+8 -: PW];
    rs[1] = ram_rdata[2*PW+8 -: PW];
    rs[2] = ram_rdata[PW+8 -: PW];
    ra    = ram_rdata[8:0];
    if (cmd_i.kind == srgbmip_pkg::K_ONE) begin
      for (int ch = 0; ch < 3; ch++) begin
        t[ch] = TW'({w_q[ch], 2'b00});
      end
      ta = {a_q, 2'b00};
    end else begin
      for (int ch = 0; ch < 3; ch++) begin
        t[ch] = TW'(rs[ch]) + TW'(s[ch]);
      end
      ta = 10'(ra) + 10'(sa);
    end
    for (int ch = 0; ch < 3; ch++) begin
      r_ext[ch] = {rem_q[ch], n_q[ch][TW-1]};
      ge[ch]    = r_ext[ch] >= {1'b0, den_q};
      cand[ch]  = code_q[ch] | (8'd1 << cmd_i.enc_bit);
    end
  end

  assign ram_wdata = {s[0], s[1], s[2], sa};
  assign ram_we    = cmd_i.acc && (cmd_i.kind == srgbmip_pkg::K_UPPER);
  assign div_load  = cmd_i.acc && (cmd_i.kind == srgbmip_pkg::K_LOWER ||
                                   cmd_i.kind == srgbmip_pkg::K_ONE);

  srgbmip_ram #(
    .Width(RamW),
    .Depth(RamD)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (rd_idx_i),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx_i),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int ch = 0; ch < 3; ch++) begin
        lin_q[ch] <= DecRom[pin[ch]][LB-1:0];
      end
      a_q <= alpha_i;
    end
    if (cmd_i.mul) begin
      for (int ch = 0; ch < 3; ch++) begin
        w_q[ch] <= WW'(lin_q[ch]) * WW'(a_q);
      end
    end
    if (cmd_i.acc && cmd_i.kind == srgbmip_pkg::K_EVEN) begin
      for (int ch = 0; ch < 3; ch++) begin
        p_q[ch] <= w_q[ch];
      end
      pa_q <= a_q;
    end
    if (div_load) begin
      for (int ch = 0; ch < 3; ch++) begin
        n_q[ch]    <= t[ch] + TW'(ta[9:1]);
        rem_q[ch]  <= '0;
        code_q[ch] <= '0;
      end
      den_q  <= ta;
      zero_q <= (ta == '0);
      asum_q <= ta;
      done_q <= cmd_i.done;
    end
    if (cmd_i.div_step) begin
      for (int ch = 0; ch < 3; ch++) begin
        rem_q[ch] <= ge[ch] ? 10'(r_ext[ch] - {1'b0, den_q}) : r_ext[ch][9:0];
        n_q[ch]   <= {n_q[ch][TW-2:0], ge[ch]};
      end
    end
    if (cmd_i.enc_step) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (EncThr[cand[ch]][LB-1:0] <= n_q[ch][LB-1:0]) begin
          code_q[ch] <= cand[ch];
        end
      end
    end
    if (cmd_i.emit) begin
      red_o       <= zero_q ? 8'd0 : code_q[0];
      green_o     <= zero_q ? 8'd0 : code_q[1];
      blue_o      <= zero_q ? 8'd0 : code_q[2];
      alpha_o     <= 8'((asum_q + 10'd2) >> 2);
      tile_done_o <= done_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sts_o.out_busy  = out_valid_q && !out_ready_i;

endmodule

// ----- hw/rtl/srgb_alpha_weighted_mip_downsample.sv -----
// Top level: sRGB-correct alpha-weighted 2x2 mip downsampler.
//
//   channel  direction  handshake        payload
//   src_i    in         valid/ready      red_in green_in blue_in alpha_in
//   dst_o    out        valid/ready      red_out green_out blue_out alpha_out tile_done
//   cfg      in         cfg_we_i         cfg_wdata_i (tile_size)
//
// A pixel that yields no output passes through accept, weight and accumulate steps.
// A pixel that completes a block then passes through the bit-serial restoring dividers
// and the 8-step threshold search of the encoders before its result is emitted.
// Reset clears control only; the row accumulator RAM is undefined until written.
// A finished pixel waits in the output register while further requests are accepted;
// the sequencer holds only when the next result needs that register.
module srgb_alpha_weighted_mip_downsample #(
  parameter int unsigned TILE_MAX    = srgbmip_pkg::TileMaxDefault,
  parameter int unsigned LINEAR_BITS = srgbmip_pkg::LinearBitsDefault
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  srgbmip_in_if.sink           src_i,
  srgbmip_out_if.source        dst_o,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i
);

  localparam int unsigned HalfMax = TILE_MAX / 2;
  localparam int unsigned AddrW   = (HalfMax > 1) ? $clog2(HalfMax) : 1;

  srgbmip_pkg::cmd_t cmd;
  srgbmip_pkg::sts_t sts;
  logic [AddrW-1:0]  rd_idx;

  srgbmip_ctrl #(
    .TILE_MAX    (TILE_MAX),
    .LINEAR_BITS (LINEAR_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (src_i.valid),
    .in_ready_o  (src_i.ready),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_o       (cmd),
    .rd_idx_o    (rd_idx),
    .sts_i       (sts)
  );

  srgbmip_dp #(
    .TILE_MAX    (TILE_MAX),
    .LINEAR_BITS (LINEAR_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .red_i       (src_i.red_in),
    .green_i     (src_i.green_in),
    .blue_i      (src_i.blue_in),
    .alpha_i     (src_i.alpha_in),
    .cmd_i       (cmd),
    .rd_idx_i    (rd_idx),
    .sts_o       (sts),
    .out_ready_i (dst_o.ready),
    .out_valid_o (dst_o.valid),
    .red_o       (dst_o.red_out),
    .green_o     (dst_o.green_out),
    .blue_o      (dst_o.blue_out),
    .alpha_o     (dst_o.alpha_out),
    .tile_done_o (dst_o.tile_done)
  );

endmodule

// ----- hw/rtl/srgbmip_chk.sv -----
// Checker: port-level assertions for the mip downsampler, bound to the top level.
module srgbmip_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] alpha_out_i
);

  logic in_acc;
  assign in_acc = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(alpha_out_i))
    else $error("output request dropped or changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input accepted on consecutive cycles");

  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> !$past(in_acc, 1) && !$past(in_acc, 2))
    else $error("result appeared too soon after an accepted request");

endmodule

bind srgb_alpha_weighted_mip_downsample srgbmip_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (src_i.valid),
  .in_ready_i  (src_i.ready),
  .out_valid_i (dst_o.valid),
  .out_ready_i (dst_o.ready),
  .alpha_out_i (dst_o.alpha_out)
);

// ----- test/srgb_alpha_weighted_mip_downsample_test.sv -----
// Testbench: directed and random tiles through the sRGB mip downsampler, checked against a predictor.
`timescale 1ns / 1ps

module srgb_alpha_weighted_mip_downsample_test;

  typedef struct {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       done;
  } mip_pixel_t;

  typedef struct {
    int         size;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    bit         known;
    logic [7:0] want_red;
    logic [7:0] want_green;
    logic [7:0] want_blue;
    logic [7:0] want_alpha;
    logic       want_done;
  } plan_row_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  srgbmip_in_if  src ();
  srgbmip_out_if dst ();

  srgb_alpha_weighted_mip_downsample DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .src_i      (src),
    .dst_o      (dst),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  logic [31:0] lin_rom [256];
  logic [31:0] enc_step [256];
  logic [7:0]  tile_reg;
  int unsigned col_pos;
  int unsigned row_pos;
  logic [63:0] held_pair [4];
  logic [63:0] upper_red [64];
  logic [63:0] upper_green [64];
  logic [63:0] upper_blue [64];
  logic [63:0] upper_alpha [64];
  mip_pixel_t  pending_pixels [$];
  plan_row_t   plan [$];
  int          fails;
  int          cycles;
  bit          calm;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [63:0] q30_pow5(input logic [63:0] v);
    logic [63:0] v2;
    logic [63:0] v4;
    v2 = (v * v) >> 30;
    v4 = (v2 * v2) >> 30;
    return (v4 * v) >> 30;
  endfunction

  function automatic logic [31:0] srgb_to_q16(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] l;
    logic [63:0] q;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] t4;
    logic [63:0] t8;
    logic [63:0] t12;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    if (num * 100000 <= den * 4045) begin
      l = ((num * 100) << 30) / (den * 1292);
    end else begin
      t   = ((num * 1000 + den * 55) << 30) / (den * 1055);
      t2  = (t * t) >> 30;
      t4  = (t2 * t2) >> 30;
      t8  = (t4 * t4) >> 30;
      t12 = (t8 * t4) >> 30;
      lo  = 0;
      hi  = 64'd1 << 30;
      while (lo < hi) begin
        mid = lo + ((hi - lo + 1) >> 1);
        if (q30_pow5(mid) <= t12) begin
          lo = mid;
        end else begin
          hi = mid - 1;
        end
      end
      l = lo;
    end
    q = ((l << 16) + (64'd1 << 29)) >> 30;
    if (q > 64'd65535) begin
      q = 64'd65535;
    end
    return q[31:0];
  endfunction

  function automatic logic [7:0] q16_to_srgb(input logic [63:0] q);
    logic [7:0] n;
    n = 0;
    for (int k = 1; k < 256; k++) begin
      if (q >= enc_step[k]) begin
        n++;
      end
    end
    return n;
  endfunction

  function automatic mip_pixel_t resolve_block(input logic [63:0] wr, input logic [63:0] wg,
                                               input logic [63:0] wb, input logic [63:0] asum,
                                               input logic done);
    mip_pixel_t p;
    p.alpha = 8'((asum + 2) >> 2);
    p.done  = done;
    if (asum == 0) begin
      p.red   = 0;
      p.green = 0;
      p.blue  = 0;
    end else begin
      p.red   = q16_to_srgb((wr + asum / 2) / asum);
      p.green = q16_to_srgb((wg + asum / 2) / asum);
      p.blue  = q16_to_srgb((wb + asum / 2) / asum);
    end
    return p;
  endfunction

  function automatic bit downsample_step(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b, input logic [7:0] a,
                                         output mip_pixel_t res);
    int unsigned size;
    int unsigned half;
    int unsigned idx;
    logic [63:0] wr;
    logic [63:0] wg;
    logic [63:0] wb;
    logic [63:0] sr;
    logic [63:0] sg;
    logic [63:0] sb;
    logic [63:0] sa;
    bit          made;
    made = 0;
    size = (tile_reg == 0) ? 1 : (tile_reg > 128) ? 128 : tile_reg;
    half = size / 2;
    wr = 64'(lin_rom[r]) * a;
    wg = 64'(lin_rom[g]) * a;
    wb = 64'(lin_rom[b]) * a;
    if (size == 1) begin
      res = resolve_block(wr * 4, wg * 4, wb * 4, 64'(a) * 4, 1'b1);
      col_pos = 0;
      row_pos = 0;
      return 1;
    end
    if (col_pos < 2 * half && row_pos < 2 * half) begin
      if (col_pos[0] == 1'b0) begin
        held_pair[0] = wr;
        held_pair[1] = wg;
        held_pair[2] = wb;
        held_pair[3] = a;
      end else begin
        idx = col_pos >> 1;
        sr = held_pair[0] + wr;
        sg = held_pair[1] + wg;
        sb = held_pair[2] + wb;
        sa = held_pair[3] + a;
        if (row_pos[0] == 1'b0) begin
          upper_red[idx]   = sr;
          upper_green[idx] = sg;
          upper_blue[idx]  = sb;
          upper_alpha[idx] = sa;
        end else begin
          res = resolve_block(upper_red[idx] + sr, upper_green[idx] + sg,
                              upper_blue[idx] + sb, upper_alpha[idx] + sa,
                              row_pos == 2 * half - 1 && col_pos == 2 * half - 1);
          made = 1;
        end
      end
    end
    col_pos++;
    if (col_pos >= size) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= size) begin
        row_pos = 0;
      end
    end
    return made;
  endfunction

  task automatic drain();
    src.valid = 1'b0;
    while (pending_pixels.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_tile_size(input logic [7:0] v);
    drain();
    repeat (60) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we   = 1'b0;
    tile_reg = v;
    col_pos  = 0;
    row_pos  = 0;
  endtask

  task automatic send_pixel(input plan_row_t p);
    mip_pixel_t res;
    if (!calm && $urandom_range(99) < 7) begin
      src.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    src.valid    = 1'b1;
    src.red_in   = p.red;
    src.green_in = p.green;
    src.blue_in  = p.blue;
    src.alpha_in = p.alpha;
    do @(posedge clk); while (!src.ready);
    if (downsample_step(p.red, p.green, p.blue, p.alpha, res)) begin
      if (p.known) begin
        res = '{p.want_red, p.want_green, p.want_blue, p.want_alpha, p.want_done};
      end
      pending_pixels.push_back(res);
    end
    @(negedge clk);
  endtask

  function automatic plan_row_t random_pixel();
    plan_row_t p;
    int unsigned mode;
    p.size  = -1;
    p.known = 0;
    p.red   = 8'($urandom);
    p.green = 8'($urandom);
    p.blue  = 8'($urandom);
    mode    = $urandom_range(9);
    p.alpha = (mode < 2) ? 8'd0 : (mode < 4) ? 8'd255 : 8'($urandom);
    return p;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      dst.ready <= 1'b0;
    end else begin
      dst.ready <= calm || ($urandom_range(99) >= 7);
    end
  end

  always @(posedge clk) begin
    mip_pixel_t want;
    if (rst_n && dst.valid && dst.ready) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected request: red %0d green %0d blue %0d alpha %0d done %0d",
               dst.red_out, dst.green_out, dst.blue_out, dst.alpha_out, dst.tile_done);
        fails++;
      end else begin
        want = pending_pixels.pop_front();
        if (dst.red_out !== want.red) begin
          $error("red_out: expected %0d, got %0d", want.red, dst.red_out);
          fails++;
        end
        if (dst.green_out !== want.green) begin
          $error("green_out: expected %0d, got %0d", want.green, dst.green_out);
          fails++;
        end
        if (dst.blue_out !== want.blue) begin
          $error("blue_out: expected %0d, got %0d", want.blue, dst.blue_out);
          fails++;
        end
        if (dst.alpha_out !== want.alpha) begin
          $error("alpha_out: expected %0d, got %0d", want.alpha, dst.alpha_out);
          fails++;
        end
        if (dst.tile_done !== want.done) begin
          $error("tile_done: expected %0d, got %0d", want.done, dst.tile_done);
          fails++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 600000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int        sent;
    int        phase;
    int        size;
    int        count;
    plan_row_t p;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = 8'd0;
    src.valid    = 1'b0;
    src.red_in   = 8'd0;
    src.green_in = 8'd0;
    src.blue_in  = 8'd0;
    src.alpha_in = 8'd0;
    fails        = 0;
    cycles       = 0;
    calm         = 0;
    sent         = 0;
    tile_reg     = 8'd128;
    col_pos      = 0;
    row_pos      = 0;
    for (int i = 0; i < 256; i++) begin
      lin_rom[i] = srgb_to_q16(64'(i), 64'd255);
    end
    enc_step[0] = 0;
    for (int i = 1; i < 256; i++) begin
      enc_step[i] = srgb_to_q16(64'(2 * i - 1), 64'd510);
    end

    // size, pixel, typed expectation where obvious
    plan.push_back('{-1, 8'd10, 8'd20, 8'd30, 8'd40, 0, 0, 0, 0, 0, 0});
    plan.push_back('{-1, 8'd250, 8'd5, 8'd128, 8'd255, 0, 0, 0, 0, 0, 0});
    plan.push_back('{1, 8'd255, 8'd255, 8'd255, 8'd255, 1, 255, 255, 255, 255, 1});
    plan.push_back('{-1, 8'd0, 8'd0, 8'd0, 8'd0, 1, 0, 0, 0, 0, 1});
    plan.push_back('{-1, 8'd200, 8'd100, 8'd50, 8'd0, 1, 0, 0, 0, 0, 1});
    plan.push_back('{-1, 8'd77, 8'd1, 8'd254, 8'd128, 0, 0, 0, 0, 0, 0});
    plan.push_back('{0, 8'd255, 8'd0, 8'd255, 8'd255, 1, 255, 0, 255, 255, 1});
    plan.push_back('{2, 8'd255, 8'd17, 8'd99, 8'd0, 0, 0, 0, 0, 0, 0});
    plan.push_back('{-1, 8'd3, 8'd255, 8'd0, 8'd0, 0, 0, 0, 0, 0, 0});
    plan.push_back('{-1, 8'd128, 8'd128, 8'd128, 8'd0, 0, 0, 0, 0, 0, 0});
    plan.push_back('{-1, 8'd64, 8'd32, 8'd16, 8'd0, 1, 0, 0, 0, 0, 1});
    for (int i = 0; i < 4; i++) begin
      plan.push_back('{-1, 8'd255, 8'd255, 8'd255, 8'd255, i == 3, 255, 255, 255, 255, 1});
    end
    plan.push_back('{3, 8'd12, 8'd200, 8'd99, 8'd255, 0, 0, 0, 0, 0, 0});
    for (int i = 0; i < 8; i++) begin
      p = random_pixel();
      plan.push_back(p);
    end
    plan.push_back('{255, 8'd1, 8'd2, 8'd3, 8'd4, 0, 0, 0, 0, 0, 0});
    plan.push_back('{-1, 8'd254, 8'd253, 8'd252, 8'd251, 0, 0, 0, 0, 0, 0});

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].size >= 0) begin
        write_tile_size(8'(plan[i].size));
      end
      send_pixel(plan[i]);
      sent++;
    end

    phase = 0;
    while (sent < 900) begin
      calm  = (phase >= 6 && phase < 12);
      count = $urandom_range(99);
      if (count < 10) begin
        size  = 1;
        count = $urandom_range(6, 20);
      end else if (count < 22) begin
        size  = 2 * $urandom_range(1, 4) + 1;
        count = size * size;
      end else if (count < 26) begin
        size  = 16;
        count = size * size;
      end else if (count < 32) begin
        size  = $urandom_range(2, 10);
        count = $urandom_range(1, size * size - 1);
      end else begin
        size  = 2 * $urandom_range(1, 4);
        count = size * size * $urandom_range(1, 2);
      end
      if (count > 900 - sent) begin
        count = 900 - sent;
      end
      write_tile_size(8'(size));
      for (int i = 0; i < count; i++) begin
        p = random_pixel();
        send_pixel(p);
        sent++;
        if (phase == 3 && i == count / 2) begin
          drain();
          @(negedge clk);
        end
      end
      phase++;
    end
    calm = 0;

    drain();
    repeat (60) @(negedge clk);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/srgbmip_pkg.sv
hw/rtl/srgbmip_if.sv
hw/rtl/srgbmip_ram.sv
hw/rtl/srgbmip_ctrl.sv
hw/rtl/srgbmip_dp.sv
hw/rtl/srgb_alpha_weighted_mip_downsample.sv
hw/rtl/srgbmip_chk.sv
test/srgb_alpha_weighted_mip_downsample_test.sv
